// File: rtl/kmc_pkg.sv
`timescale 1ns / 1ps

package kmc_pkg;

    // build defaults
    localparam int MAX_KMER_LENGTH_DEF = 10;
    localparam int COUNT_WIDTH_DEF     = 32;

    // fixed field widths
    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 4;
    localparam int OUT_COUNT_W = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = 4'd10;

    // ascii bases
    localparam logic [CHAR_W-1:0] CHAR_UA = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UC = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_UG = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_UT = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_LA = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC = 8'h63;
    localparam logic [CHAR_W-1:0] CHAR_LG = 8'h67;
    localparam logic [CHAR_W-1:0] CHAR_LT = 8'h74;

    // 2-bit base codes
    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    typedef struct packed {
        logic bad;
        logic [1:0] code;
    } t_base_dec;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic take;
        logic read_issue;
        logic finish;
    } t_kmc_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic direct;
    } t_kmc_status;

    function automatic t_base_dec decode_base(input logic [CHAR_W-1:0] c);
        t_base_dec d;
        d.bad  = 1'b0;
        d.code = CODE_A;
        case (c)
            CHAR_UA, CHAR_LA: d.code = CODE_A;
            CHAR_UC, CHAR_LC: d.code = CODE_C;
            CHAR_UG, CHAR_LG: d.code = CODE_G;
            CHAR_UT, CHAR_LT: d.code = CODE_T;
            default:          d.bad  = 1'b1;
        endcase
        return d;
    endfunction

endpackage

// File: rtl/kmc_if.sv
`timescale 1ns / 1ps

// base input channel
interface kmc_in_if;
    import kmc_pkg::*;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [CHAR_W-1:0] base_char;
    logic              region_start;

    modport source (output valid, mode, base_char, region_start, input ready);
    modport sink   (input valid, mode, base_char, region_start, output ready);
endinterface

// result channel
interface kmc_out_if;
    import kmc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   kmer_ready;
    logic [OUT_COUNT_W-1:0] kmer_count;
    logic                   bad_base;

    modport source (output valid, kmer_ready, kmer_count, bad_base, input ready);
    modport sink   (input valid, kmer_ready, kmer_count, bad_base, output ready);
endinterface

// configuration write channel
interface kmc_cfg_if;
    import kmc_pkg::*;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] kmer_length;

    modport source (output valid, kmer_length, input ready);
    modport sink   (input valid, kmer_length, output ready);
endinterface

// File: rtl/kmc_ram.sv
`timescale 1ns / 1ps

module kmc_ram #(
    parameter int              WIDTH = 32,
    parameter longint unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/kmc_ctrl.sv
`timescale 1ns / 1ps

module kmc_ctrl
    import kmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    input  t_kmc_status i_status,
    output t_kmc_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   take;

    // accept only when idle and the result slot is free or draining
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd            = '0;
        o_cmd.clear_step = (r_state == ST_CLEAR);
        o_cmd.take       = take;
        o_cmd.read_issue = (r_state == ST_LOOKUP);
        o_cmd.finish     = (r_state == ST_UPDATE);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (take && !i_status.direct) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // result slot occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if ((take && i_status.direct) || (r_state == ST_UPDATE)) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/kmc_dp.sv
`timescale 1ns / 1ps

module kmc_dp
    import kmc_pkg::*;
#(
    parameter int MAX_KMER_LENGTH = MAX_KMER_LENGTH_DEF,
    parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_kmc_cmd               i_cmd,
    output t_kmc_status            o_status,
    input  logic                   i_cfg_we,
    input  logic [LEN_W-1:0]       i_cfg_len,
    input  logic                   i_mode,
    input  logic [CHAR_W-1:0]      i_base_char,
    input  logic                   i_region_start,
    output logic                   o_kmer_ready,
    output logic [OUT_COUNT_W-1:0] o_kmer_count,
    output logic                   o_bad_base
);

    localparam int              CODE_W      = 2 * MAX_KMER_LENGTH;
    localparam int              BIW_W       = $clog2(MAX_KMER_LENGTH + 1);
    localparam longint unsigned TABLE_DEPTH = 64'd1 << CODE_W;

    // window and configuration
    logic [LEN_W-1:0]  r_len;
    logic [CODE_W-1:0] r_fwd, r_rev;
    logic [BIW_W-1:0]  r_biw;

    // item in flight
    logic [CODE_W-1:0] r_canon;
    logic              r_mode;

    // clearing pass
    logic [CODE_W-1:0] r_clr_addr;

    // result payload
    logic                   r_out_ready;
    logic [OUT_COUNT_W-1:0] r_out_count;
    logic                   r_out_bad;

    t_base_dec         dec;
    logic [BIW_W-1:0]  k, k_m1;
    logic [CODE_W-1:0] mask;
    logic [CODE_W-1:0] fwd_base, rev_base, rev_ins;
    logic [BIW_W-1:0]  biw_base;
    logic [CODE_W-1:0] n_fwd, n_rev, n_canon;
    logic [BIW_W-1:0]  n_biw;

    logic [COUNT_WIDTH-1:0] rd_cnt, cnt_inc;
    logic                   do_inc;
    logic                   ram_we;
    logic [CODE_W-1:0]      ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;

    // effective k-mer length, clamped to 1..max
    always_comb begin
        if (r_len == '0) begin
            k = BIW_W'(1);
        end else if (int'(r_len) > MAX_KMER_LENGTH) begin
            k = BIW_W'(MAX_KMER_LENGTH);
        end else begin
            k = BIW_W'(r_len);
        end
        k_m1 = k - 1'b1;
    end

    // low 2k bits kept
    always_comb begin
        for (int i = 0; i < MAX_KMER_LENGTH; i++) begin
            mask[2*i +: 2] = (i < int'(k)) ? 2'b11 : 2'b00;
        end
    end

    // rolling window update
    always_comb begin
        dec      = decode_base(i_base_char);
        fwd_base = i_region_start ? '0 : r_fwd;
        rev_base = i_region_start ? '0 : r_rev;
        biw_base = i_region_start ? '0 : r_biw;
        rev_ins  = CODE_W'(~dec.code) << {k_m1, 1'b0};
        n_fwd    = ((fwd_base << 2) | CODE_W'(dec.code)) & mask;
        n_rev    = ((rev_base >> 2) | rev_ins) & mask;
        n_biw    = (biw_base < k) ? biw_base + 1'b1 : k;
        n_canon  = (n_fwd <= n_rev) ? n_fwd : n_rev;
    end

    assign o_status.direct     = dec.bad || (n_biw != k);
    assign o_status.clear_last = &r_clr_addr;

    // window and length registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
            r_fwd <= '0;
            r_rev <= '0;
            r_biw <= '0;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_len;
            r_fwd <= '0;
            r_rev <= '0;
            r_biw <= '0;
        end else if (i_cmd.take) begin
            if (dec.bad) begin
                r_fwd <= '0;
                r_rev <= '0;
                r_biw <= '0;
            end else begin
                r_fwd <= n_fwd;
                r_rev <= n_rev;
                r_biw <= n_biw;
            end
        end
    end

    // clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_canon <= n_canon;
            r_mode  <= i_mode;
        end
    end

    // saturating increment
    assign cnt_inc = rd_cnt + 1'b1;
    assign do_inc  = i_cmd.finish && !r_mode && !(&rd_cnt);

    // counter table write port shared by clearing pass and update
    assign ram_we    = i_cmd.clear_step || do_inc;
    assign ram_waddr = i_cmd.clear_step ? r_clr_addr : r_canon;
    assign ram_wdata = i_cmd.clear_step ? '0 : cnt_inc;

    kmc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.read_issue),
        .i_raddr (r_canon),
        .o_rdata (rd_cnt)
    );

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && o_status.direct) begin
            r_out_ready <= 1'b0;
            r_out_count <= '0;
            r_out_bad   <= dec.bad;
        end else if (i_cmd.finish) begin
            r_out_ready <= 1'b1;
            r_out_count <= OUT_COUNT_W'(do_inc ? cnt_inc : rd_cnt);
            r_out_bad   <= 1'b0;
        end
    end

    assign o_kmer_ready = r_out_ready;
    assign o_kmer_count = r_out_count;
    assign o_bad_base   = r_out_bad;

endmodule

// File: rtl/canonical_kmer_counter_top.sv
`timescale 1ns / 1ps

// canonical k-mer counter
// i_in carries one base beat (mode, base_char, region_start); o_out returns
// exactly one result beat per base (kmer_ready, kmer_count, bad_base);
// i_cfg writes kmer_length and is always ready. a length write clears the
// window but keeps the counts; the user must issue it only while no base
// is pending (the block does not enforce this). a base that completes no
// k-mer (bad base or window still filling) gives its result in the cycle
// after acceptance; a full k-mer is read from the counter table in the
// lookup state and counted in the update state, which loads its result.
// one base is in flight at a time: one base per cycle for short results
// while the receiver takes them; a counted k-mer holds off the next base
// until its table read-modify-write is done. reset clears the window, sets
// kmer_length to 10 and runs a clearing pass over all 4^MAX_KMER_LENGTH
// table entries (1048576 at the default), one entry per cycle; i_in is not
// ready during the pass. a stalled receiver holds the result beat; a new
// base is accepted in the cycle the waiting result is taken.
module canonical_kmer_counter_top
    import kmc_pkg::*;
#(
    parameter int MAX_KMER_LENGTH = MAX_KMER_LENGTH_DEF,
    parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kmc_in_if.sink    i_in,
    kmc_out_if.source o_out,
    kmc_cfg_if.sink   i_cfg
);

    t_kmc_cmd    cmd;
    t_kmc_status status;

    assign i_cfg.ready = 1'b1;

    kmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    kmc_dp #(
        .MAX_KMER_LENGTH (MAX_KMER_LENGTH),
        .COUNT_WIDTH     (COUNT_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_len      (i_cfg.kmer_length),
        .i_mode         (i_in.mode),
        .i_base_char    (i_in.base_char),
        .i_region_start (i_in.region_start),
        .o_kmer_ready   (o_out.kmer_ready),
        .o_kmer_count   (o_out.kmer_count),
        .o_bad_base     (o_out.bad_base)
    );

endmodule

// File: rtl/kmc_checker.sv
`timescale 1ns / 1ps

module kmc_checker
    import kmc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic [CHAR_W-1:0]      i_base_char,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic                   i_kmer_ready,
    input logic [OUT_COUNT_W-1:0] i_kmer_count,
    input logic                   i_bad_base
);

    logic good_char;

    assign good_char = (i_base_char == CHAR_UA) || (i_base_char == CHAR_LA) ||
                       (i_base_char == CHAR_UC) || (i_base_char == CHAR_LC) ||
                       (i_base_char == CHAR_UG) || (i_base_char == CHAR_LG) ||
                       (i_base_char == CHAR_UT) || (i_base_char == CHAR_LT);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kmer_ready)
            && $stable(i_kmer_count) && $stable(i_bad_base))
        else $error("result beat changed while stalled");

    // no k-mer means a zero count
    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_kmer_ready |-> i_kmer_count == '0)
        else $error("count reported without a full k-mer");

    // a bad base never completes a k-mer
    a_bad_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_bad_base |-> !i_kmer_ready)
        else $error("bad base flagged together with a k-mer");

    // a bad base is reported in the next cycle
    a_bad_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !good_char |=> i_out_valid && i_bad_base)
        else $error("bad base result missing");

endmodule

bind canonical_kmer_counter_top kmc_checker u_kmc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_base_char  (i_in.base_char),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_kmer_ready (o_out.kmer_ready),
    .i_kmer_count (o_out.kmer_count),
    .i_bad_base   (o_out.bad_base)
);
